### hw/rtl/stx_etx_frame_receiver_defines.svh
// Assertion macros shared by the frame receiver RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef STX_ETX_FRAME_RECEIVER_DEFINES_SVH
`define STX_ETX_FRAME_RECEIVER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define STXR_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("stxr: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define STXR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("stxr: next-cycle check failed");

`endif

### hw/rtl/stxr_pkg.sv
// Types and constants of the STX/ETX frame receiver.
// No dependencies; used by the channel interfaces and every RTL module.
package stxr_pkg;

   localparam int BYTE_W    = 8;
   localparam int STATUS_W  = 3;
   localparam int LEN_OUT_W = 6;
   localparam int POS_OUT_W = 6;
   localparam int CSR_IDX_W = 1;

   localparam logic [BYTE_W-1:0] START_MARK   = 8'h02;
   localparam logic [BYTE_W-1:0] END_MARK     = 8'h03;
   localparam logic [BYTE_W-1:0] ACK_CODE_RST = 8'h06;
   localparam logic [BYTE_W-1:0] FWD_ADDR_RST = 8'h0F;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ACK_CODE = 1'b0,
      CSR_FWD_ADDR = 1'b1
   } csr_idx_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 3'd0,
      ST_BAD_END  = 3'd1,
      ST_TOO_LONG = 3'd2,
      ST_BAD_XOR  = 3'd3,
      ST_OVERFLOW = 3'd4
   } status_type;

   // Payload store write from the parser
   typedef struct packed {
      logic              en;
      logic [BYTE_W-1:0] addr;
      logic [BYTE_W-1:0] data;
   } wr_type;

   // Frame verdict handed from the parser to the report generator
   typedef struct packed {
      logic              vld;
      status_type        status;
      logic [BYTE_W-1:0] sender;
      logic [BYTE_W-1:0] destination;
      logic [BYTE_W-1:0] node_type;
      logic [BYTE_W-1:0] len;
      logic              ack;
      logic              fwd;
   } evt_type;

   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic [BYTE_W-1:0]    sender;
      logic [BYTE_W-1:0]    destination;
      logic [BYTE_W-1:0]    node_type;
      logic [LEN_OUT_W-1:0] payload_length;
      logic [BYTE_W-1:0]    payload_byte;
      logic [POS_OUT_W-1:0] byte_position;
      logic                 has_data;
      logic                 ack_requested;
      logic                 forward_requested;
      logic                 last;
   } res_type;

endpackage

### hw/rtl/stxr_channels.sv
// Valid/ready channel interfaces of the frame receiver: byte requests in, reports out.
// Depends on stxr_pkg.
interface stxr_req_if;
   import stxr_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;
   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface stxr_rsp_if;
   import stxr_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [STATUS_W-1:0]  status;
   logic [BYTE_W-1:0]    sender;
   logic [BYTE_W-1:0]    destination;
   logic [BYTE_W-1:0]    node_type;
   logic [LEN_OUT_W-1:0] payload_length;
   logic [BYTE_W-1:0]    payload_byte;
   logic [POS_OUT_W-1:0] byte_position;
   logic                 has_data;
   logic                 ack_requested;
   logic                 forward_requested;
   logic                 last;
   modport source (
      output valid, output status, output sender, output destination, output node_type,
      output payload_length, output payload_byte, output byte_position, output has_data,
      output ack_requested, output forward_requested, output last, input ready
   );
   modport sink (
      input valid, input status, input sender, input destination, input node_type,
      input payload_length, input payload_byte, input byte_position, input has_data,
      input ack_requested, input forward_requested, input last, output ready
   );
endinterface

### hw/rtl/stx_etx_frame_receiver.sv
// Top level of the STX/ETX frame receiver: CSRs, byte parser and report generator.
// Depends on stxr_pkg, stxr_channels, stxr_frame_parser and stxr_report_gen.
//
//   Port     Dir  Handshake      Carries
//   req_if   in   valid/ready    rx_byte, one bus byte per request
//   rsp_if   out  valid/ready    one report item (status, header, payload byte, flags)
//   csr_*    in   csr_we         ack_code (index 0), forward_address (index 1)
//
// One request per cycle unless stalled. A valid frame with N payload bytes yields N items
// (one if N is 0), one per cycle from the sequencer unless stalled, and requests are held
// after its end byte while the store is read out.
// Synchronous active-high reset clears control state; no clearing pass is needed.
// Back-pressure on rsp_if stalls the output register, the read stage, then req_if.
module stx_etx_frame_receiver #(
   parameter int BUFFER_BYTES = 40,
   parameter int MAX_PAYLOAD  = 34
) (
   input  logic                             clock,
   input  logic                             reset,
   stxr_req_if.sink                         req_if,
   stxr_rsp_if.source                       rsp_if,
   input  logic                             csr_we,
   input  logic [stxr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [stxr_pkg::BYTE_W-1:0]      csr_wdata
);
   import stxr_pkg::*;

   logic [BYTE_W-1:0] ack_code_ff, ack_code_in;
   logic [BYTE_W-1:0] fwd_addr_ff, fwd_addr_in;

   evt_type evt;
   wr_type  wr;
   logic    evt_ready;
   res_type res;

   always_comb begin
      ack_code_in = ack_code_ff;
      fwd_addr_in = fwd_addr_ff;
      if (csr_we) begin
         unique case (csr_idx_type'(csr_index))
            CSR_ACK_CODE: ack_code_in = csr_wdata;
            CSR_FWD_ADDR: fwd_addr_in = csr_wdata;
            default:      ack_code_in = ack_code_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ack_code_ff <= ACK_CODE_RST;
         fwd_addr_ff <= FWD_ADDR_RST;
      end else begin
         ack_code_ff <= ack_code_in;
         fwd_addr_ff <= fwd_addr_in;
      end
   end

   stxr_frame_parser #(
      .BUFFER_BYTES (BUFFER_BYTES),
      .MAX_PAYLOAD  (MAX_PAYLOAD)
   ) u_parser (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_if.valid),
      .req_ready       (req_if.ready),
      .req_rx_byte     (req_if.rx_byte),
      .ack_code        (ack_code_ff),
      .forward_address (fwd_addr_ff),
      .evt_ready       (evt_ready),
      .evt             (evt),
      .wr              (wr)
   );

   stxr_report_gen #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_report (
      .clock     (clock),
      .reset     (reset),
      .evt       (evt),
      .evt_ready (evt_ready),
      .wr        (wr),
      .rsp_ready (rsp_if.ready),
      .rsp_valid (rsp_if.valid),
      .res       (res)
   );

   assign rsp_if.status            = res.status;
   assign rsp_if.sender            = res.sender;
   assign rsp_if.destination       = res.destination;
   assign rsp_if.node_type         = res.node_type;
   assign rsp_if.payload_length    = res.payload_length;
   assign rsp_if.payload_byte      = res.payload_byte;
   assign rsp_if.byte_position     = res.byte_position;
   assign rsp_if.has_data          = res.has_data;
   assign rsp_if.ack_requested     = res.ack_requested;
   assign rsp_if.forward_requested = res.forward_requested;
   assign rsp_if.last              = res.last;

endmodule

### hw/rtl/stxr_frame_parser.sv
// Byte parser: input register, frame position, header capture, XOR and verdict.
// Depends on stxr_pkg; feeds stxr_report_gen.
module stxr_frame_parser #(
   parameter int BUFFER_BYTES = 40,
   parameter int MAX_PAYLOAD  = 34
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [stxr_pkg::BYTE_W-1:0]   req_rx_byte,
   input  logic [stxr_pkg::BYTE_W-1:0]   ack_code,
   input  logic [stxr_pkg::BYTE_W-1:0]   forward_address,
   input  logic                          evt_ready,
   output stxr_pkg::evt_type             evt,
   output stxr_pkg::wr_type              wr
);
   import stxr_pkg::*;

   localparam int CNT_W = $clog2(BUFFER_BYTES);
   localparam int CMP_W = ((CNT_W > BYTE_W) ? CNT_W : BYTE_W) + 1;
   localparam logic [CMP_W-1:0] OVF_COUNT   = CMP_W'(BUFFER_BYTES - 1);
   localparam logic [CMP_W-1:0] MAX_LEN     = CMP_W'(MAX_PAYLOAD);
   localparam logic [CMP_W-1:0] TRAILER     = CMP_W'(6);
   localparam logic [CNT_W-1:0] POS_SENDER  = CNT_W'(1);
   localparam logic [CNT_W-1:0] POS_DEST    = CNT_W'(2);
   localparam logic [CNT_W-1:0] POS_NTYPE   = CNT_W'(3);
   localparam logic [CNT_W-1:0] POS_LEN     = CNT_W'(4);
   localparam logic [CNT_W-1:0] POS_PAYLOAD = CNT_W'(5);

   logic              byte_vld_ff, byte_vld_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic              in_frame_ff, in_frame_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [BYTE_W-1:0] sender_ff, sender_in;
   logic [BYTE_W-1:0] dest_ff, dest_in;
   logic [BYTE_W-1:0] ntype_ff, ntype_in;
   logic [BYTE_W-1:0] len_ff, len_in;
   logic [BYTE_W-1:0] xor_ff, xor_in;
   logic [BYTE_W-1:0] first_ff, first_in;

   logic             go;
   logic [CMP_W-1:0] count_next;
   logic [CMP_W-1:0] pay_off;

   assign go        = byte_vld_ff && evt_ready;
   assign req_ready = !byte_vld_ff || go;

   always_comb begin
      byte_vld_in = byte_vld_ff;
      byte_in     = byte_ff;
      if (req_ready) begin
         byte_vld_in = req_valid;
         byte_in     = req_rx_byte;
      end
   end

   assign count_next = CMP_W'(count_ff) + CMP_W'(1);
   assign pay_off    = CMP_W'(count_ff) - CMP_W'(POS_PAYLOAD);

   always_comb begin
      in_frame_in = in_frame_ff;
      count_in    = count_ff;
      sender_in   = sender_ff;
      dest_in     = dest_ff;
      ntype_in    = ntype_ff;
      len_in      = len_ff;
      xor_in      = xor_ff;
      first_in    = first_ff;

      evt.vld         = 1'b0;
      evt.status      = ST_OK;
      evt.sender      = sender_ff;
      evt.destination = dest_ff;
      evt.node_type   = ntype_ff;
      evt.len         = len_ff;
      evt.ack         = (len_ff != '0) && (first_ff == ack_code);
      evt.fwd         = (dest_ff == forward_address);

      wr.en   = 1'b0;
      wr.addr = BYTE_W'(pay_off);
      wr.data = byte_ff;

      if (go) begin
         priority if (byte_ff == START_MARK) begin
            // a start byte always opens a fresh frame
            in_frame_in = 1'b1;
            count_in    = POS_SENDER;
            sender_in   = '0;
            dest_in     = '0;
            ntype_in    = '0;
            len_in      = '0;
            xor_in      = '0;
         end else if (in_frame_ff && byte_ff == END_MARK) begin
            in_frame_in = 1'b0;
            count_in    = '0;
            evt.vld     = 1'b1;
            priority if (CMP_W'(count_ff) != CMP_W'(len_ff) + TRAILER) begin
               evt.status = ST_BAD_END;
            end else if (CMP_W'(len_ff) > MAX_LEN) begin
               evt.status = ST_TOO_LONG;
            end else if (xor_ff != '0) begin
               evt.status = ST_BAD_XOR;
            end else begin
               evt.status = ST_OK;
            end
         end else if (in_frame_ff) begin
            priority if (count_ff == POS_SENDER) begin
               sender_in = byte_ff;
            end else if (count_ff == POS_DEST) begin
               dest_in = byte_ff;
            end else if (count_ff == POS_NTYPE) begin
               ntype_in = byte_ff;
            end else if (count_ff == POS_LEN) begin
               len_in = byte_ff;
            end else begin
               // payload and checksum both go into the running XOR
               xor_in = xor_ff ^ byte_ff;
               wr.en  = (pay_off < MAX_LEN);
               if (count_ff == POS_PAYLOAD) begin
                  first_in = byte_ff;
               end
            end
            count_in = CNT_W'(count_next);
            if (count_next >= OVF_COUNT) begin
               in_frame_in = 1'b0;
               count_in    = '0;
               evt.vld     = 1'b1;
               evt.status  = ST_OVERFLOW;
            end
         end else begin
            // drop bytes outside a frame
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_vld_ff <= 1'b0;
         in_frame_ff <= 1'b0;
         count_ff    <= '0;
      end else begin
         byte_vld_ff <= byte_vld_in;
         in_frame_ff <= in_frame_in;
         count_ff    <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff   <= byte_in;
      sender_ff <= sender_in;
      dest_ff   <= dest_in;
      ntype_ff  <= ntype_in;
      len_ff    <= len_in;
      xor_ff    <= xor_in;
      first_ff  <= first_in;
   end

endmodule

### hw/rtl/stxr_report_gen.sv
// Report generator: payload store, per-byte sequencer, read stage and output register.
// Depends on stxr_pkg and stx_etx_frame_receiver_defines.svh; fed by stxr_frame_parser.
module stxr_report_gen #(
   parameter int MAX_PAYLOAD = 34
) (
   input  logic              clock,
   input  logic              reset,
   input  stxr_pkg::evt_type evt,
   output logic              evt_ready,
   input  stxr_pkg::wr_type  wr,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   output stxr_pkg::res_type res
);
   import stxr_pkg::*;
   `include "stx_etx_frame_receiver_defines.svh"

   localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

   logic [BYTE_W-1:0] mem [MAX_PAYLOAD];
   logic [BYTE_W-1:0] rd_data_ff;
   logic [ADDR_W-1:0] rd_addr;
   logic              issue;

   logic              busy_ff, busy_in;
   logic [ADDR_W-1:0] k_ff, k_in;
   evt_type           cmd_ff, cmd_in;

   logic              a_vld_ff, a_vld_in;
   res_type           a_ff, a_in;
   logic              b_vld_ff, b_vld_in;
   res_type           b_ff, b_in;

   logic    a_can, b_can;
   res_type beat;
   logic    seq_last;

   assign b_can     = !b_vld_ff || rsp_ready;
   assign a_can     = !a_vld_ff || b_can;
   assign evt_ready = !busy_ff && a_can;
   assign seq_last  = (BYTE_W'(k_ff) == cmd_ff.len - BYTE_W'(1));

   always_comb begin
      issue   = 1'b0;
      rd_addr = '0;
      beat    = '0;
      busy_in = busy_ff;
      k_in    = k_ff;
      cmd_in  = cmd_ff;
      if (busy_ff) begin
         issue                  = a_can;
         rd_addr                = k_ff;
         beat.status            = ST_OK;
         beat.sender            = cmd_ff.sender;
         beat.destination       = cmd_ff.destination;
         beat.node_type         = cmd_ff.node_type;
         beat.payload_length    = LEN_OUT_W'(cmd_ff.len);
         beat.byte_position     = POS_OUT_W'(k_ff);
         beat.has_data          = 1'b1;
         beat.ack_requested     = cmd_ff.ack;
         beat.forward_requested = cmd_ff.fwd;
         beat.last              = seq_last;
         if (a_can) begin
            // advance to the next payload byte or drop out after the last
            if (seq_last) begin
               busy_in = 1'b0;
            end else begin
               k_in = k_ff + ADDR_W'(1);
            end
         end
      end else if (evt.vld) begin
         issue = 1'b1;
         if (evt.status != ST_OK) begin
            beat.status = evt.status;
            beat.last   = 1'b1;
         end else begin
            beat.status            = ST_OK;
            beat.sender            = evt.sender;
            beat.destination       = evt.destination;
            beat.node_type         = evt.node_type;
            beat.payload_length    = LEN_OUT_W'(evt.len);
            beat.has_data          = (evt.len != '0);
            beat.ack_requested     = evt.ack;
            beat.forward_requested = evt.fwd;
            beat.last              = (evt.len <= BYTE_W'(1));
            if (evt.len > BYTE_W'(1)) begin
               busy_in = 1'b1;
               k_in    = ADDR_W'(1);
               cmd_in  = evt;
            end
         end
      end
   end

   always_comb begin
      a_vld_in = a_vld_ff;
      a_in     = a_ff;
      if (a_can) begin
         a_vld_in = issue;
         a_in     = beat;
      end
      b_vld_in = b_vld_ff;
      b_in     = b_ff;
      if (b_can) begin
         b_vld_in          = a_vld_ff;
         b_in              = a_ff;
         b_in.payload_byte = a_ff.has_data ? rd_data_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr[ADDR_W-1:0]] <= wr.data;
      end
      // read data holds with stage A while the output stalls
      if (issue) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         a_vld_ff <= a_vld_in;
         b_vld_ff <= b_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff   <= k_in;
      cmd_ff <= cmd_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
   end

   assign rsp_valid = b_vld_ff;
   assign res       = b_ff;

   `STXR_ASSERT_SAME(a_no_write_in_report, clock, reset, wr.en, !busy_ff)
   `STXR_ASSERT_SAME(a_error_single, clock, reset, rsp_valid && res.status != ST_OK, res.last && !res.has_data)
   `STXR_ASSERT_SAME(a_report_start, clock, reset, $rose(busy_ff), a_vld_ff && !a_ff.last)

endmodule

### test/stx_etx_frame_receiver_tb.sv
// Self-checking bench for the STX/ETX frame receiver: byte requests in, frame reports out.
// Depends on stxr_pkg, the stxr_channels interfaces and the stx_etx_frame_receiver RTL.
module stx_etx_frame_receiver_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import stxr_pkg::*;

   localparam int BUFFER_BYTES  = 40;
   localparam int MAX_PAYLOAD   = 34;
   localparam int SETTLE_CYCLES = 12;
   localparam int HOLD_CYCLES   = 250;
   localparam int LIMIT_CYCLES  = 400000;

   typedef enum int {
      FLAW_NONE,
      FLAW_XOR,
      FLAW_LENGTH,
      FLAW_MARK
   } flaw_type;

   // Frame predictor and queue of expected reports
   class frame_report_board;
      logic [7:0]  ack_code;
      logic [7:0]  fwd_address;
      bit          in_frame;
      int unsigned byte_count;
      logic [7:0]  hdr_sender;
      logic [7:0]  hdr_destination;
      logic [7:0]  hdr_node_type;
      logic [7:0]  hdr_length;
      logic [7:0]  xor_acc;
      logic [7:0]  payload [MAX_PAYLOAD];
      res_type     expected_reports [$];
      int          errors;

      function new();
         ack_code    = ACK_CODE_RST;
         fwd_address = FWD_ADDR_RST;
         in_frame    = 1'b0;
         byte_count  = 0;
         errors      = 0;
      endfunction

      function int pending();
         return expected_reports.size();
      endfunction

      function void push_error(status_type code);
         res_type want;
         want        = '0;
         want.status = code;
         want.last   = 1'b1;
         expected_reports.push_back(want);
      endfunction

      function void note_request(logic [7:0] b);
         res_type     want;
         int unsigned n;
         bit          ack;
         if (b == START_MARK) begin
            in_frame        = 1'b1;
            byte_count      = 1;
            hdr_sender      = '0;
            hdr_destination = '0;
            hdr_node_type   = '0;
            hdr_length      = '0;
            xor_acc         = '0;
            return;
         end
         if (!in_frame) return;
         if (b == END_MARK) begin
            in_frame = 1'b0;
            if (byte_count != hdr_length + 6) push_error(ST_BAD_END);
            else if (hdr_length > MAX_PAYLOAD) push_error(ST_TOO_LONG);
            else if (xor_acc != 8'h00) push_error(ST_BAD_XOR);
            else begin
               ack = (hdr_length > 0) && (payload[0] == ack_code);
               n   = (hdr_length == 0) ? 1 : hdr_length;
               for (int unsigned k = 0; k < n; k++) begin
                  want                   = '0;
                  want.status            = ST_OK;
                  want.sender            = hdr_sender;
                  want.destination       = hdr_destination;
                  want.node_type         = hdr_node_type;
                  want.payload_length    = hdr_length[5:0];
                  want.payload_byte      = (hdr_length > 0) ? payload[k] : 8'h00;
                  want.byte_position     = (hdr_length > 0) ? k[5:0] : 6'd0;
                  want.has_data          = (hdr_length > 0);
                  want.ack_requested     = ack;
                  want.forward_requested = (hdr_destination == fwd_address);
                  want.last              = (k + 1 == n);
                  expected_reports.push_back(want);
               end
            end
            byte_count = 0;
            return;
         end
         case (byte_count)
            1: hdr_sender      = b;
            2: hdr_destination = b;
            3: hdr_node_type   = b;
            4: hdr_length      = b;
            default: begin
               xor_acc ^= b;
               if (byte_count - 5 < MAX_PAYLOAD) payload[byte_count - 5] = b;
            end
         endcase
         byte_count++;
         if (byte_count >= BUFFER_BYTES - 1) begin
            in_frame   = 1'b0;
            byte_count = 0;
            push_error(ST_OVERFLOW);
         end
      endfunction

      function void check_field(string name, logic [7:0] want, logic [7:0] got);
         if (want !== got) begin
            errors++;
            $display("%0t: report %s expected %0h actual %0h", $time, name, want, got);
         end
      endfunction

      function void check_report(res_type got);
         res_type want;
         if (expected_reports.size() == 0) begin
            errors++;
            $display("%0t: report expected none actual status %0d byte %0h last %0b",
                     $time, got.status, got.payload_byte, got.last);
            return;
         end
         want = expected_reports.pop_front();
         check_field("status", 8'(want.status), 8'(got.status));
         check_field("sender", want.sender, got.sender);
         check_field("destination", want.destination, got.destination);
         check_field("node_type", want.node_type, got.node_type);
         check_field("payload_length", 8'(want.payload_length), 8'(got.payload_length));
         check_field("payload_byte", want.payload_byte, got.payload_byte);
         check_field("byte_position", 8'(want.byte_position), 8'(got.byte_position));
         check_field("has_data", 8'(want.has_data), 8'(got.has_data));
         check_field("ack_requested", 8'(want.ack_requested), 8'(got.ack_requested));
         check_field("forward_requested", 8'(want.forward_requested),
                     8'(got.forward_requested));
         check_field("last", 8'(want.last), 8'(got.last));
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [BYTE_W-1:0]    csr_wdata;

   stxr_req_if req_if ();
   stxr_rsp_if rsp_if ();

   frame_report_board board = new();

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_trigger  = 0;
   int req_count     = 0;

   stx_etx_frame_receiver #(
      .BUFFER_BYTES(BUFFER_BYTES),
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_if   (req_if),
      .rsp_if   (rsp_if),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   function automatic bit is_mark(logic [7:0] b);
      return (b == START_MARK) || (b == END_MARK);
   endfunction

   function automatic logic [7:0] plain_byte();
      logic [7:0] b;
      do b = 8'($urandom); while (is_mark(b));
      return b;
   endfunction

   // Lengths of 2 and 3 would read as marks in the length field
   function automatic int pick_length();
      int len;
      if ($urandom_range(99) < 80) begin
         do len = $urandom_range(0, 8); while (len == 2 || len == 3);
      end else begin
         len = $urandom_range(4, 32);
      end
      return len;
   endfunction

   task automatic send_byte(input logic [7:0] value);
      if ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.rx_byte <= value;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      board.note_request(value);
      req_count++;
   endtask

   task automatic send_frame(input int len, input bit want_ack, input bit want_fwd,
                             input flaw_type flaw);
      logic [7:0] frame_q [$];
      logic [7:0] body [$];
      logic [7:0] sum;
      logic [7:0] len_field;
      int         at;
      for (int k = 0; k < len; k++) body.push_back(plain_byte());
      if (len > 0 && want_ack) body[0] = board.ack_code;
      // Regenerate the last byte until the checksum cannot pass for a mark
      forever begin
         sum = 8'h00;
         foreach (body[k]) sum ^= body[k];
         if (!is_mark(sum)) break;
         body[len - 1] = plain_byte();
      end
      len_field = 8'(len);
      if (flaw == FLAW_XOR) begin
         do sum = sum ^ 8'($urandom_range(1, 255)); while (is_mark(sum));
      end
      if (flaw == FLAW_LENGTH) begin
         do len_field = plain_byte(); while (len_field == 8'(len));
      end
      frame_q.push_back(START_MARK);
      frame_q.push_back(plain_byte());
      frame_q.push_back(want_fwd ? board.fwd_address : plain_byte());
      frame_q.push_back(plain_byte());
      frame_q.push_back(len_field);
      foreach (body[k]) frame_q.push_back(body[k]);
      frame_q.push_back(sum);
      frame_q.push_back(END_MARK);
      if (flaw == FLAW_MARK) begin
         at          = $urandom_range(1, frame_q.size() - 2);
         frame_q[at] = $urandom_range(1) ? START_MARK : END_MARK;
      end
      foreach (frame_q[k]) send_byte(frame_q[k]);
   endtask

   task automatic send_overflow();
      send_byte(START_MARK);
      repeat (BUFFER_BYTES - 2) send_byte(plain_byte());
   endtask

   task automatic set_config(input logic [7:0] ack, input logic [7:0] fwd);
      csr_we    <= 1'b1;
      csr_index <= CSR_ACK_CODE;
      csr_wdata <= ack;
      @(posedge clock);
      board.ack_code = ack;
      csr_index <= CSR_FWD_ADDR;
      csr_wdata <= fwd;
      @(posedge clock);
      board.fwd_address = fwd;
      csr_we <= 1'b0;
   endtask

   // Hold requests until every expected report is in, then let the pipe settle
   task automatic wait_idle();
      if (board.in_frame) send_byte(END_MARK);
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(input int byte_goal);
      int start;
      int r;
      start = req_count;
      while (req_count - start < byte_goal) begin
         r = $urandom_range(99);
         if (r < 60)
            send_frame(pick_length(), $urandom_range(3) == 0, $urandom_range(3) == 0,
                       FLAW_NONE);
         else if (r < 70)
            send_frame(pick_length(), $urandom_range(1), $urandom_range(1), FLAW_XOR);
         else if (r < 78)
            send_frame(pick_length(), 1'b0, $urandom_range(1), FLAW_LENGTH);
         else if (r < 86)
            send_frame(pick_length(), $urandom_range(1), 1'b0, FLAW_MARK);
         else if (r < 89)
            send_overflow();
         else
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
      end
      wait_idle();
   endtask

   // Report side: check accepted reports and drive ready
   initial begin : report_side
      res_type got;
      int      hold_left;
      int      seen_trigger;
      hold_left    = 0;
      seen_trigger = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready) begin
            got.status            = rsp_if.status;
            got.sender            = rsp_if.sender;
            got.destination       = rsp_if.destination;
            got.node_type         = rsp_if.node_type;
            got.payload_length    = rsp_if.payload_length;
            got.payload_byte      = rsp_if.payload_byte;
            got.byte_position     = rsp_if.byte_position;
            got.has_data          = rsp_if.has_data;
            got.ack_requested     = rsp_if.ack_requested;
            got.forward_requested = rsp_if.forward_requested;
            got.last              = rsp_if.last;
            board.check_report(got);
         end
         if (hold_trigger != seen_trigger) begin
            seen_trigger = hold_trigger;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   initial begin : watchdog
      int cycles;
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > LIMIT_CYCLES) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   initial begin : stimulus
      logic [7:0] opening [$] = '{
         8'h03, 8'h55,
         8'h02, 8'hFF, 8'h00, 8'h01, 8'h00, 8'h00, 8'h03,
         8'h02, 8'h00, 8'h0F, 8'hFF, 8'h01, 8'h06, 8'h06, 8'h03,
         8'h02, 8'h11, 8'h02, 8'h22, 8'h33, 8'h44, 8'h00, 8'h00, 8'h03,
         8'h02, 8'h05, 8'h03,
         8'h02, 8'h01, 8'h04, 8'h05, 8'h01, 8'h10, 8'h11, 8'h03
      };
      int start;
      reset          <= 1'b1;
      req_if.valid   <= 1'b0;
      req_if.rx_byte <= '0;
      csr_we         <= 1'b0;
      csr_index      <= CSR_ACK_CODE;
      csr_wdata      <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Stray bytes, empty frame, ack and forward, restart in header, early end, bad checksum
      foreach (opening[k]) send_byte(opening[k]);
      wait_idle();

      set_config(8'h00, 8'hFF);
      send_overflow();
      send_frame(32, 1'b1, 1'b1, FLAW_NONE);
      run_phase(22);

      set_config(8'hFF, 8'h00);
      send_idle_pct = 82;
      run_phase(22);

      set_config(plain_byte(), plain_byte());
      send_idle_pct = 0;
      rsp_stall_pct = 82;
      run_phase(22);

      set_config(ACK_CODE_RST, FWD_ADDR_RST);
      send_idle_pct = 36;
      rsp_stall_pct = 36;
      run_phase(22);

      // Hold the report side off while long frames keep coming, so requests back up
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_trigger++;
      start = req_count;
      while (req_count - start < 25) send_frame($urandom_range(12, 32), 1'b0, 1'b0, FLAW_NONE);
      wait_idle();

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (board.errors == 0 && board.pending() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/stxr_pkg.sv
hw/rtl/stxr_channels.sv
hw/rtl/stxr_frame_parser.sv
hw/rtl/stxr_report_gen.sv
hw/rtl/stx_etx_frame_receiver.sv
test/stx_etx_frame_receiver_tb.sv
